// ===== rtl/qdp_pkg.sv =====
// Package for the quantized block dot product core.
// Types, constants and float helper functions; no dependencies.
package qdp_pkg;

  localparam int unsigned NumLanes   = 4;
  localparam int unsigned ElemPerLn  = 4;   // weight bytes per lane
  localparam int unsigned LaneSumW   = 15;  // 8 products, |p| <= 1024
  localparam int unsigned SumW       = 17;  // 32 products, |sum| <= 32768
  localparam logic [3:0]  NibBias    = 4'd8;
  localparam logic [31:0] CanonNan   = 32'h7FC0_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_ADD
  } state_e;

  // exact fp16 -> fp32 conversion
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [7:0]  e;
    logic [31:0] r;
    logic        found;
    ex = h[14:10];
    man = h[9:0];
    r = {h[15], 31'd0};
    if (ex == 5'd0) begin
      if (man != 10'd0) begin
        e = 8'd113;
        found = 1'b0;
        // leading one search over 10 bits
        for (int i = 9; i >= 0; i--) begin
          if (!found && man[i]) begin
            found = 1'b1;
            e = 8'(113 - (10 - i));
            man = 10'(man << (10 - i));
          end
        end
        r = {h[15], e, man, 13'd0};
      end
    end else if (ex == 5'd31) begin
      r = {h[15], 8'hFF, man, 13'd0};
    end else begin
      r = {h[15], 8'(ex) + 8'd112, man, 13'd0};
    end
    return r;
  endfunction

  // fp32 multiply, NaN/inf aware: normalize the 48-bit product, round nearest even
  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [9:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] p;
    logic signed [11:0] e;
    logic [49:0] sh;
    logic [23:0] m;
    logic        g, st, inc;
    logic [24:0] mr;
    logic [31:0] r;
    s = a[31] ^ b[31];
    ea = {2'd0, a[30:23]};
    eb = {2'd0, b[30:23]};
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    if (a[30:23] == 8'd0) ea = 10'd1;
    if (b[30:23] == 8'd0) eb = 10'd1;
    r = {s, 31'd0};
    if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0)) begin
      r = CanonNan;
    end else if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) r = CanonNan;
      else r = {s, 8'hFF, 23'd0};
    end else if (ma != 24'd0 && mb != 24'd0) begin
      p = ma * mb;
      // value = p * 2^(ea+eb-254-46) ; normalize so bit 47 leads
      e = 12'(ea) + 12'(eb) - 12'sd126;  // exponent if bit 47 leads
      for (int i = 0; i < 47; i++) begin
        if (p[47] == 1'b0) begin
          p = p << 1;
          e = e - 12'sd1;
        end
      end
      sh = {p, 2'b00};
      if (e < 12'sd1) begin
        // subnormal: shift right, keep sticky
        for (int i = 0; i < 50; i++) begin
          if (e < 12'sd1) begin
            sh = {1'b0, sh[49:2], sh[1] | sh[0]};
            e = e + 12'sd1;
          end
        end
        e = 12'sd0;
      end
      m = sh[49:26];
      g = sh[25];
      st = |sh[24:0];
      inc = g & (st | m[0]);
      mr = {1'b0, m} + 25'(inc);
      if (mr[24]) begin
        mr = mr >> 1;
        e = e + 12'sd1;
      end else if (e == 12'sd0 && mr[23]) begin
        e = 12'sd1;
      end
      if (e >= 12'sd255) r = {s, 8'hFF, 23'd0};
      else r = {s, e[7:0], mr[22:0]};
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x, y, r;
    logic [7:0]  ex, ey;
    logic [26:0] mx, my;
    logic [7:0]  d;
    logic [27:0] sm;
    logic signed [10:0] e;
    logic [23:0] m;
    logic        g, st, inc, s;
    logic [24:0] mr;
    if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0)) begin
      r = CanonNan;
    end else if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
      if (a[30:23] == 8'hFF && b[30:23] == 8'hFF && a[31] != b[31]) r = CanonNan;
      else if (a[30:23] == 8'hFF) r = a;
      else r = b;
    end else begin
      if (a[30:0] >= b[30:0]) begin x = a; y = b; end
      else begin x = b; y = a; end
      ex = (x[30:23] == 0) ? 8'd1 : x[30:23];
      ey = (y[30:23] == 0) ? 8'd1 : y[30:23];
      mx = {(x[30:23] != 0), x[22:0], 3'd0};
      my = {(y[30:23] != 0), y[22:0], 3'd0};
      d = ex - ey;
      for (int i = 0; i < 27; i++) begin
        if (8'(i) < d) my = {1'b0, my[26:2], my[1] | my[0]};
      end
      s = x[31];
      if (x[31] == y[31]) sm = {1'b0, mx} + {1'b0, my};
      else sm = {1'b0, mx} - {1'b0, my};
      e = 11'(ex);
      if (sm == 28'd0) begin
        r = {(a[31] & b[31]), 31'd0};
      end else begin
        if (sm[27]) begin
          sm = {1'b0, sm[27:2], sm[1] | sm[0]};
          e = e + 11'sd1;
        end else begin
          for (int i = 0; i < 26; i++) begin
            if (!sm[26] && e > 11'sd1) begin
              sm = sm << 1;
              e = e - 11'sd1;
            end
          end
          if (!sm[26]) e = 11'sd0;
        end
        m = sm[26:3];
        g = sm[2];
        st = sm[1] | sm[0];
        inc = g & (st | m[0]);
        mr = {1'b0, m} + 25'(inc);
        if (mr[24]) begin
          mr = mr >> 1;
          e = e + 11'sd1;
        end else if (e == 11'sd0 && mr[23]) begin
          e = 11'sd1;
        end
        if (e >= 11'sd255) r = {s, 8'hFF, 23'd0};
        else r = {s, e[7:0], mr[22:0]};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/qdp_lane.sv =====
// One dot product lane: four weight bytes against eight activations.
// Depends on qdp_pkg.
module qdp_lane (
  input  logic [31:0] wbytes_i,
  input  logic [31:0] act_lo_i,
  input  logic [31:0] act_hi_i,
  output logic signed [qdp_pkg::LaneSumW-1:0] sum_o
);
  import qdp_pkg::*;

  always_comb begin
    logic signed [LaneSumW-1:0] acc;
    logic signed [4:0] wl, wh;
    acc = '0;
    for (int k = 0; k < ElemPerLn; k++) begin
      wl = $signed({1'b0, wbytes_i[8*k +: 4]}) - $signed({1'b0, NibBias});
      wh = $signed({1'b0, wbytes_i[8*k+4 +: 4]}) - $signed({1'b0, NibBias});
      acc = acc + LaneSumW'(wl * $signed(act_lo_i[8*k +: 8]))
                + LaneSumW'(wh * $signed(act_hi_i[8*k +: 8]));
    end
    sum_o = acc;
  end
endmodule

// ===== rtl/q4_q8_block_dot_product_core.sv =====
// Top level of the quantized q4 x q8 block dot product core.
// Depends on qdp_pkg and qdp_lane.
//
// Usage: one input beat carries a block pair (16 weight bytes, 32 int8
// activations, two fp16 scales, last flag). Four lanes form partial
// integer sums in the accept cycle, which are merged and registered.
// Then: ST_MUL1 int->float and scale_x multiply, ST_MUL2 scale_y
// multiply, ST_ADD float accumulate. A block is taken only once the
// last one is through ST_ADD, as the serial float multiply/add chain
// runs on the loop-carried accumulator. in_ready_o is high in idle only.
// On a last block the sum is written to an output register, valid the
// cycle after the accumulate, and the accumulator clears. While that
// result waits on out_ready_i, new blocks are still taken; only a
// second last block finishing with the result register full stalls.
// Reset clears the accumulator to +0 and empties the output register.
module q4_q8_block_dot_product_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] weight_nibbles_lo_i,
  input  logic [63:0] weight_nibbles_hi_i,
  input  logic [63:0] act_bytes_0_i,
  input  logic [63:0] act_bytes_1_i,
  input  logic [63:0] act_bytes_2_i,
  input  logic [63:0] act_bytes_3_i,
  input  logic [15:0] weight_scale_i,
  input  logic [15:0] act_scale_i,
  input  logic        last_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] dot_result_o
);
  import qdp_pkg::*;

  logic [127:0] wb;
  logic [255:0] ab;
  logic signed [LaneSumW-1:0] lane_sum [NumLanes];
  logic signed [SumW-1:0] sum_d, sum_q;
  state_e state_q, state_d;
  logic [31:0] acc_q, prod_q, sy_q, sx_q;
  logic [31:0] new_acc;
  logic        last_q, in_fire, add_fire;

  function automatic logic [31:0] int_to_fp(input logic signed [SumW-1:0] v);
    logic [SumW-1:0] m;
    logic [7:0] e;
    logic [31:0] r;
    m = v[SumW-1] ? SumW'(-v) : SumW'(v);
    r = '0;
    if (m != '0) begin
      e = 8'(127 + SumW - 1);
      for (int i = 0; i < SumW; i++) begin
        if (!m[SumW-1]) begin
          m = m << 1;
          e = e - 8'd1;
        end
      end
      r = {v[SumW-1], e, m[SumW-2:0], {(24 - SumW){1'b0}}};
    end
    return r;
  endfunction

  assign wb = {weight_nibbles_hi_i, weight_nibbles_lo_i};
  assign ab = {act_bytes_3_i, act_bytes_2_i, act_bytes_1_i, act_bytes_0_i};

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    qdp_lane u_lane (
      .wbytes_i (wb[32*l +: 32]),
      .act_lo_i (ab[32*l +: 32]),
      .act_hi_i (ab[128+32*l +: 32]),
      .sum_o    (lane_sum[l])
    );
  end

  always_comb begin
    sum_d = '0;
    for (int l = 0; l < NumLanes; l++) sum_d = sum_d + SumW'(lane_sum[l]);
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  // a last block may only finish when the result register is free
  assign add_fire   = (state_q == ST_ADD) && !(last_q && out_valid_o && !out_ready_i);
  assign new_acc    = fp_add(acc_q, prod_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_ADD;
      ST_ADD:  if (add_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (add_fire && last_q) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (add_fire) begin
        if (last_q) begin
          acc_q <= '0;
        end else begin
          acc_q <= new_acc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sum_q  <= sum_d;
      sx_q   <= half_to_single(weight_scale_i);
      sy_q   <= half_to_single(act_scale_i);
      last_q <= last_block_i;
    end
    // |sum| <= 2^15, so the int->float conversion is exact
    if (state_q == ST_MUL1) prod_q <= fp_mul(int_to_fp(sum_q), sx_q);
    if (state_q == ST_MUL2) prod_q <= fp_mul(prod_q, sy_q);
    if (add_fire && last_q) dot_result_o <= new_acc;
  end

endmodule

// ===== rtl/qdp_checker.sv =====
// Port-level checker for the q4 x q8 block dot product core.
// Depends on q4_q8_block_dot_product_core (bound to it below).
module qdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] dot_result_o
);
  // an accepted beat holds in_ready_o low while the core works on it
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after an accepted beat");

  a_busy3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##2 !in_ready_o)
    else $error("ready too early");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dot_result_o))
    else $error("stalled result changed");

  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dot_result_o[30:23] == 8'hFF && dot_result_o[22:0] != 23'd0
      |-> dot_result_o == 32'h7FC0_0000)
    else $error("non canonical NaN");
endmodule

bind q4_q8_block_dot_product_core qdp_checker u_qdp_checker (.*);

// ===== tb/sv/q4_q8_block_dot_product_checker.sv =====
// Scoreboard for the q4 x q8 block dot product core: watches both channels,
// predicts each emitted dot product and compares it. No package dependency.
`timescale 1ns / 1ps

module q4_q8_block_dot_product_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] weight_nibbles_lo_i,
  input  logic [63:0] weight_nibbles_hi_i,
  input  logic [63:0] act_bytes_0_i,
  input  logic [63:0] act_bytes_1_i,
  input  logic [63:0] act_bytes_2_i,
  input  logic [63:0] act_bytes_3_i,
  input  logic [15:0] weight_scale_i,
  input  logic [15:0] act_scale_i,
  input  logic        last_block_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] dot_result_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o
);

  localparam logic [31:0] QuietNan = 32'h7FC0_0000;

  logic [31:0] acc_q;
  logic [31:0] dot_expected_q[$];

  // round mag * 2^lsb_exp to single precision, nearest even
  function automatic logic [31:0] fp32_round_pack(input logic sgn, input int lsb_exp,
                                                  input logic [79:0] mag);
    int          msb, sh, be;
    logic [79:0] m;
    logic        g, st;
    if (mag == '0) return {sgn, 31'd0};
    msb = 0;
    for (int i = 0; i < 80; i++) if (mag[i]) msb = i;
    sh = msb - 23;
    if (sh < -149 - lsb_exp) sh = -149 - lsb_exp;
    g = 1'b0;
    st = 1'b0;
    if (sh <= 0) begin
      m = mag << (-sh);
    end else if (sh > 79) begin
      m = '0;
      st = 1'b1;
    end else begin
      m = mag >> sh;
      g = mag[sh-1];
      st = (mag & ((80'd1 << (sh - 1)) - 80'd1)) != '0;
    end
    if (g && (st || m[0])) m = m + 80'd1;
    if (m[24]) begin
      m = m >> 1;
      sh = sh + 1;
    end
    be = m[23] ? lsb_exp + sh + 150 : 0;
    if (be >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, be[7:0], m[22:0]};
  endfunction

  function automatic logic [31:0] fp32_from_half(input logic [15:0] h);
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
    if (h[14:10] == 5'd0) return fp32_round_pack(h[15], -24, 80'(h[9:0]));
    return fp32_round_pack(h[15], int'(h[14:10]) - 25, 80'({1'b1, h[9:0]}));
  endfunction

  function automatic logic is_nan(input logic [31:0] f);
    return f[30:23] == 8'hFF && f[22:0] != '0;
  endfunction

  function automatic logic is_inf(input logic [31:0] f);
    return f[30:23] == 8'hFF && f[22:0] == '0;
  endfunction

  function automatic int lsb_exp_of(input logic [31:0] f);
    return (f[30:23] == 8'd0) ? -149 : int'(f[30:23]) - 150;
  endfunction

  function automatic logic [23:0] sig_of(input logic [31:0] f);
    return {f[30:23] != 8'd0, f[22:0]};
  endfunction

  function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
    logic sgn;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return QuietNan;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == '0 || b[30:0] == '0) return QuietNan;
      return {sgn, 8'hFF, 23'd0};
    end
    return fp32_round_pack(sgn, lsb_exp_of(a) + lsb_exp_of(b),
                           80'(48'(sig_of(a)) * 48'(sig_of(b))));
  endfunction

  function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big, sml;
    logic [79:0] mb, ms;
    int          eb, es, d;
    if (is_nan(a) || is_nan(b)) return QuietNan;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return QuietNan;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == '0 && b[30:0] == '0) return {a[31] & b[31], 31'd0};
    if (lsb_exp_of(a) >= lsb_exp_of(b)) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb = lsb_exp_of(big);
    es = lsb_exp_of(sml);
    ms = 80'(sig_of(sml));
    d = eb - es;
    // far-below operand only matters as a sticky bit
    if (d > 40) begin
      if (ms != '0) ms = 80'd1;
      d = 40;
      es = eb - 40;
    end
    mb = 80'(sig_of(big)) << d;
    if (big[31] == sml[31]) return fp32_round_pack(big[31], es, mb + ms);
    if (mb == ms) return 32'd0;
    if (mb > ms) return fp32_round_pack(big[31], es, mb - ms);
    return fp32_round_pack(sml[31], es, ms - mb);
  endfunction

  function automatic int block_int_sum(input logic [127:0] wts, input logic [255:0] acts);
    int s;
    logic [7:0] wb;
    s = 0;
    for (int j = 0; j < 16; j++) begin
      wb = wts[8*j +: 8];
      s += (int'(wb[3:0]) - 8) * int'($signed(acts[8*j +: 8]));
      s += (int'(wb[7:4]) - 8) * int'($signed(acts[8*(j+16) +: 8]));
    end
    return s;
  endfunction

  function automatic logic [31:0] block_contribution(input logic [127:0] wts,
                                                     input logic [255:0] acts,
                                                     input logic [15:0] ws,
                                                     input logic [15:0] as_);
    int          s;
    logic [31:0] sf;
    s = block_int_sum(wts, acts);
    sf = fp32_round_pack(s < 0, 0, 80'(s < 0 ? -s : s));
    return fp32_mul(fp32_mul(sf, fp32_from_half(ws)), fp32_from_half(as_));
  endfunction

  assign pending_o = dot_expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] next_acc, want;
    if (!rst_ni) begin
      acc_q <= '0;
      fail_count_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (dot_expected_q.size() == 0) begin
          $error("unexpected result beat: dot_result=%h", dot_result_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = dot_expected_q.pop_front();
          if (dot_result_i !== want) begin
            $error("dot_result mismatch: expected %h actual %h", want, dot_result_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        next_acc = fp32_add(acc_q, block_contribution(
            {weight_nibbles_hi_i, weight_nibbles_lo_i},
            {act_bytes_3_i, act_bytes_2_i, act_bytes_1_i, act_bytes_0_i},
            weight_scale_i, act_scale_i));
        if (is_nan(next_acc)) next_acc = QuietNan;
        if (last_block_i) begin
          dot_expected_q.push_back(next_acc);
          acc_q <= '0;
        end else begin
          acc_q <= next_acc;
        end
      end
    end
  end

endmodule

// ===== tb/sv/q4_q8_block_dot_product_core_test.sv =====
// Testbench top for the q4 x q8 block dot product core: clock, reset,
// block stimulus and verdict. Depends on the core and its checker.
`timescale 1ns / 1ps

module q4_q8_block_dot_product_core_test;

  localparam int NumRandom = 1080;
  localparam int CycleLimit = 300000;

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready, last_block;
  logic [63:0] w_lo, w_hi, a0, a1, a2, a3;
  logic [15:0] w_scale, a_scale;
  logic [31:0] dot_result;
  int          fail_count, pending, results_seen, blocks_sent, cycle_cnt;
  logic        quiet_stretch;

  q4_q8_block_dot_product_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .weight_nibbles_lo_i(w_lo), .weight_nibbles_hi_i(w_hi),
    .act_bytes_0_i(a0), .act_bytes_1_i(a1), .act_bytes_2_i(a2), .act_bytes_3_i(a3),
    .weight_scale_i(w_scale), .act_scale_i(a_scale), .last_block_i(last_block),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .dot_result_o(dot_result)
  );

  q4_q8_block_dot_product_checker scoreboard (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .weight_nibbles_lo_i(w_lo), .weight_nibbles_hi_i(w_hi),
    .act_bytes_0_i(a0), .act_bytes_1_i(a1), .act_bytes_2_i(a2), .act_bytes_3_i(a3),
    .weight_scale_i(w_scale), .act_scale_i(a_scale), .last_block_i(last_block),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .dot_result_i(dot_result),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 27);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [15:0] rand_scale();
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) return 16'({$urandom_range(1), 15'h7C00});           // infinity
    if (pick < 6) return 16'({$urandom_range(1), 5'h1F, 10'($urandom_range(1, 1023))});
    if (pick < 10) return 16'({$urandom_range(1), 5'h00, 10'($urandom)}); // subnormal
    if (pick < 15) return 16'($urandom);
    // normal values around one keep the accumulator meaningful
    return 16'({$urandom_range(1), 5'($urandom_range(5, 20)), 10'($urandom)});
  endfunction

  task automatic send_block(input logic [63:0] wl, input logic [63:0] wh,
                            input logic [63:0] b0, input logic [63:0] b1,
                            input logic [63:0] b2, input logic [63:0] b3,
                            input logic [15:0] ws, input logic [15:0] as_,
                            input logic lst);
    w_lo = wl; w_hi = wh; a0 = b0; a1 = b1; a2 = b2; a3 = b3;
    w_scale = ws; a_scale = as_; last_block = lst;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    blocks_sent++;
    @(negedge clk);
    if (!quiet_stretch && $urandom_range(99) < 27) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic send_random(input logic lst);
    send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
               rand_scale(), rand_scale(), lst);
  endtask

  initial begin
    blocks_sent = 0;
    quiet_stretch = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {w_lo, w_hi, a0, a1, a2, a3} = '0;
    {w_scale, a_scale, last_block} = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: field extremes, scale specials, accumulate then emit
    send_block('0, '0, '0, '0, '0, '0, 16'h3C00, 16'h3C00, 1'b1);
    send_block('0, '0, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, {8{8'h80}},
               16'h7BFF, 16'h7BFF, 1'b1);
    send_block('1, '1, {8{8'h7F}}, {8{8'h7F}}, {8{8'h7F}}, {8{8'h7F}},
               16'h3C00, 16'hBC00, 1'b1);
    send_block('1, '1, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, {8{8'h80}},
               16'h0001, 16'h0001, 1'b1);
    send_block('0, '0, {8{8'h7F}}, '1, '0, {8{8'h80}}, 16'h03FF, 16'h8200, 1'b1);
    send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
               16'h7C00, 16'h3C00, 1'b0);
    send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
               16'hFC00, 16'h3C00, 1'b1);                      // -inf scale on an inf-scaled sum
    send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
               16'h7C00, 16'h0000, 1'b1);                      // inf * 0
    send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
               16'h7E01, 16'h3C00, 1'b1);                      // NaN payload
    send_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
               16'hFD55, 16'h4000, 1'b1);
    send_block('1, '1, '1, '1, '1, '1, 16'hFFFF, 16'hFFFF, 1'b1);
    send_block('0, '0, '0, '0, '0, '0, 16'h8000, 16'h3C00, 1'b1); // -0 product
    for (int i = 0; i < 6; i++) send_random(i == 5);
    send_block(64'h8888888888888888, 64'h8888888888888888, rand64(), rand64(),
               rand64(), rand64(), 16'h3C00, 16'h3C00, 1'b1);  // zero weights

    for (int i = 0; i < NumRandom; i++) begin
      quiet_stretch = (i >= 300 && i < 450);
      if (i == 600) begin
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      send_random($urandom_range(3) == 0);
    end
    quiet_stretch = 1'b0;
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d blocks incl. scale specials and back-pressure; %0d sums checked.",
             blocks_sent, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qdp_pkg.sv
rtl/qdp_lane.sv
rtl/q4_q8_block_dot_product_core.sv
rtl/qdp_checker.sv
tb/sv/q4_q8_block_dot_product_checker.sv
tb/sv/q4_q8_block_dot_product_core_test.sv
